/* hw/rtl/spc_pkg.sv */
package spc_pkg;

  localparam int CoordBits = 12;

  localparam logic [2:0] KIND_CLEAR    = 3'd0;
  localparam logic [2:0] KIND_INSERT   = 3'd1;
  localparam logic [2:0] KIND_NEAREST  = 3'd2;
  localparam logic [2:0] KIND_NEIGHBOR = 3'd3;
  localparam logic [2:0] KIND_TRAVERSE = 3'd4;

  localparam logic [2:0] DIR_PREV  = 3'd0;
  localparam logic [2:0] DIR_NEXT  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]                  kind;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic                        has_box;
    logic signed [CoordBits-1:0] box_x;
    logic signed [CoordBits-1:0] box_y;
    logic [CoordBits-1:0]        box_w;
    logic [CoordBits-1:0]        box_h;
    logic [15:0]                 tag;
    logic [5:0]                  entry_index;
    logic [2:0]                  direction;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [5:0]                  found_index;
    logic signed [CoordBits-1:0] found_x;
    logic signed [CoordBits-1:0] found_y;
    logic [15:0]                 found_tag;
    logic                        found_has_box;
    logic                        moved;
  } out_item_t;

  // one stored table entry
  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic [CoordBits-1:0]        bw;
    logic [CoordBits-1:0]        bh;
    logic [15:0]                 tag;
    logic                        has_box;
  } entry_t;

  typedef enum logic [1:0] {SEL_HOLD, SEL_NEXT, SEL_PREV, SEL_NEW} sel_t;

  typedef struct packed {
    logic rot;
    logic ins;
  } chain_ctrl_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_NEARCHK, S_INSERT, S_DONE} st_t;

  typedef enum logic [2:0] {P_FETCH, P_NEAR, P_POS, P_UP, P_DOWN} pass_t;

  function automatic logic [CoordBits-1:0] absdiff(input logic signed [CoordBits-1:0] a,
                                                   input logic signed [CoordBits-1:0] b);
    logic signed [CoordBits:0] t;
    logic signed [CoordBits:0] m;
    t = $signed({a[CoordBits-1], a}) - $signed({b[CoordBits-1], b});
    m = t[CoordBits] ? -t : t;
    return m[CoordBits-1:0];
  endfunction

endpackage

/* hw/rtl/spc_cell.sv */
module spc_cell (
  input  logic            clk,
  input  spc_pkg::sel_t   sel,
  input  spc_pkg::entry_t from_next,
  input  spc_pkg::entry_t from_prev,
  input  spc_pkg::entry_t new_e,
  output spc_pkg::entry_t e
);
  import spc_pkg::*;

  always_ff @(posedge clk) begin
    case (sel)
      SEL_HOLD: e <= e;
      SEL_NEXT: e <= from_next;
      SEL_PREV: e <= from_prev;
      SEL_NEW:  e <= new_e;
      default:  e <= e;
    endcase
  end

endmodule

/* hw/rtl/spc_chain.sv */
module spc_chain #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  logic                 clk,
  input  spc_pkg::chain_ctrl_t ctrl,
  input  logic [IW-1:0]        pos,
  input  spc_pkg::entry_t      new_e,
  output spc_pkg::entry_t      head
);
  import spc_pkg::*;

  entry_t cells [N];
  sel_t   sel   [N];

  // rotate: cell i takes cell i+1, so the head shows entry k after k shifts
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int NX = (i + 1) % N;
    localparam int PV = (i + N - 1) % N;

    always_comb begin
      if (ctrl.rot) begin
        sel[i] = SEL_NEXT;
      end else if (ctrl.ins && IW'(i) > pos) begin
        sel[i] = SEL_PREV;
      end else if (ctrl.ins && IW'(i) == pos) begin
        sel[i] = SEL_NEW;
      end else begin
        sel[i] = SEL_HOLD;
      end
    end

    spc_cell u_cell (
      .clk       (clk),
      .sel       (sel[i]),
      .from_next (cells[NX]),
      .from_prev (cells[PV]),
      .new_e     (new_e),
      .e         (cells[i])
    );
  end

  assign head = cells[0];

endmodule

/* hw/rtl/sorted_point_table_navigator.sv */
// Channel | Direction | Handshake          | Beat
// in      | input     | in_valid/in_stall  | in_item_t: command and operands
// out     | output    | out_valid/out_stall| out_item_t: one result per command
//
// One command at a time.
// Clear and rejected commands skip the ring walk. One ring walk visits N = MAX_ENTRIES cells.
// Nearest, insert, a traverse that snaps and a missing link walk the ring once.
// Neighbor and traverse that follows a link walk the ring twice.
// Reset (rst, synchronous) empties the table; entry contents are not cleared.
// A finished result waits in a holding register while the output beat stalls.
module sorted_point_table_navigator #(
  parameter int MAX_ENTRIES = 64,
  parameter int NEAR_RADIUS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spc_pkg::out_item_t out_data
);
  import spc_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = 2 * CoordBits + 1;

  // control
  st_t           state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rot_cnt, rot_cnt_next;
  logic          s1_v, s2_v, s3_v;

  // request and scan context
  in_item_t              req, req_next;
  pass_t                 pass, pass_next;
  logic [IW-1:0]         tgt, tgt_next;
  logic                  row_chk, row_chk_next;
  logic                  origin_ph, origin_ph_next;
  logic                  moved_f, moved_f_next;
  logic signed [CoordBits-1:0] ref_x, ref_x_next, ref_y, ref_y_next;
  logic [IW-1:0]         org_idx, org_idx_next;

  // running best of the walk
  logic                  hit, hit_next;
  logic [IW-1:0]         best_idx, best_idx_next;
  entry_t                best_e, best_e_next;
  logic [DW-1:0]         bestd, bestd_next;
  logic signed [CoordBits-1:0] ry2, ry2_next;
  logic [CW-1:0]         pos_cnt, pos_cnt_next;

  out_item_t             res, res_next;
  logic                  load_out;

  // scan pipeline at the ring head
  entry_t                head, s1_e, s2_e, s3_e, new_e;
  logic [IW-1:0]         s1_idx, s2_idx, s3_idx;
  logic [CoordBits-1:0]  s2_dx, s2_dy, s3_dx;
  logic [2*CoordBits-1:0] sq_x, sq_y;
  logic [DW-1:0]         s3_d2;
  chain_ctrl_t           ctrl;

  logic          rot_done, scan_done, s3_in;
  logic [CW-1:0] ip1;
  logic          lnk_miss, lnk_row;
  pass_t         lnk_pass;
  logic [IW-1:0] lnk_tgt;
  logic          near;
  logic signed [CoordBits+1:0] cx, cy, bx0, by0, bx1, by1;
  logic [IW+5:0] ei_w;
  logic [CW+5:0] ei_c, cnt_c;

  function automatic out_item_t mk_ok(input logic [IW-1:0] idx, input entry_t e,
                                      input logic mv);
    out_item_t     o;
    logic [IW+5:0] w;
    w               = {6'b0, idx};
    o.status        = ST_OK;
    o.found_index   = w[5:0];
    o.found_x       = e.x;
    o.found_y       = e.y;
    o.found_tag     = e.tag;
    o.found_has_box = e.has_box;
    o.moved         = mv;
    return o;
  endfunction

  function automatic out_item_t mk_err(input logic [1:0] st);
    out_item_t o;
    o        = '0;
    o.status = st;
    return o;
  endfunction

  spc_chain #(.N(MAX_ENTRIES), .IW(IW)) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .pos   (pos_cnt[IW-1:0]),
    .new_e (new_e),
    .head  (head)
  );

  always_comb begin
    new_e.x       = req.pos_x;
    new_e.y       = req.pos_y;
    new_e.bx      = req.box_x;
    new_e.by      = req.box_y;
    new_e.bw      = req.box_w;
    new_e.bh      = req.box_h;
    new_e.tag     = req.tag;
    new_e.has_box = req.has_box;
  end

  assign rot_done  = (rot_cnt == CW'(MAX_ENTRIES));
  assign scan_done = rot_done && !s1_v && !s2_v && !s3_v;
  assign s3_in     = CW'(s3_idx) < count;
  assign in_stall  = (state != S_IDLE);

  // link target from the origin held in best_idx / best_e
  always_comb begin
    ip1      = CW'(best_idx) + 1'b1;
    lnk_miss = 1'b0;
    lnk_row  = 1'b0;
    lnk_pass = P_FETCH;
    lnk_tgt  = '0;
    case (req.direction)
      DIR_PREV: lnk_tgt = (best_idx == '0) ? IW'(count - 1'b1) : best_idx - 1'b1;
      DIR_NEXT: lnk_tgt = (ip1 >= count) ? '0 : ip1[IW-1:0];
      DIR_LEFT: begin
        lnk_miss = (best_idx == '0);
        lnk_tgt  = best_idx - 1'b1;
        lnk_row  = 1'b1;
      end
      DIR_RIGHT: begin
        lnk_miss = (ip1 >= count);
        lnk_tgt  = ip1[IW-1:0];
        lnk_row  = 1'b1;
      end
      DIR_UP:   lnk_pass = P_UP;
      DIR_DOWN: lnk_pass = P_DOWN;
      default:  lnk_miss = 1'b1;
    endcase
  end

  // cursor near the traverse candidate: inside its box if it has one, else within the radius
  always_comb begin
    cx   = $signed({{2{req.pos_x[CoordBits-1]}}, req.pos_x});
    cy   = $signed({{2{req.pos_y[CoordBits-1]}}, req.pos_y});
    bx0  = $signed({{2{best_e.bx[CoordBits-1]}}, best_e.bx});
    by0  = $signed({{2{best_e.by[CoordBits-1]}}, best_e.by});
    bx1  = bx0 + $signed({2'b00, best_e.bw});
    by1  = by0 + $signed({2'b00, best_e.bh});
    if (best_e.has_box) begin
      near = (cx >= bx0) && (cx < bx1) && (cy >= by0) && (cy < by1);
    end else begin
      near = (absdiff(req.pos_x, best_e.x) <= CoordBits'(NEAR_RADIUS)) &&
             (absdiff(req.pos_y, best_e.y) <= CoordBits'(NEAR_RADIUS));
    end
  end

  always_comb begin
    ei_w  = {{IW{1'b0}}, in_data.entry_index};
    ei_c  = {{CW{1'b0}}, in_data.entry_index};
    cnt_c = {6'b0, count};
  end

  // full-width squares of the axis distances
  always_comb begin
    sq_x = s2_dx * s2_dx;
    sq_y = s2_dy * s2_dy;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    rot_cnt_next   = rot_cnt;
    req_next       = req;
    pass_next      = pass;
    tgt_next       = tgt;
    row_chk_next   = row_chk;
    origin_ph_next = origin_ph;
    moved_f_next   = moved_f;
    ref_x_next     = ref_x;
    ref_y_next     = ref_y;
    org_idx_next   = org_idx;
    hit_next       = hit;
    best_idx_next  = best_idx;
    best_e_next    = best_e;
    bestd_next     = bestd;
    ry2_next       = ry2;
    pos_cnt_next   = pos_cnt;
    res_next       = res;
    load_out       = 1'b0;
    ctrl           = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next       = in_data;
          moved_f_next   = 1'b0;
          origin_ph_next = 1'b0;
          hit_next       = 1'b0;
          pos_cnt_next   = '0;
          rot_cnt_next   = '0;
          ref_x_next     = in_data.pos_x;
          ref_y_next     = in_data.pos_y;
          state_next     = S_DONE;
          case (in_data.kind)
            KIND_CLEAR: begin
              count_next = '0;
              res_next   = mk_err(ST_OK);
            end
            KIND_INSERT: begin
              if (count >= CW'(MAX_ENTRIES)) begin
                res_next = mk_err(ST_FULL);
              end else begin
                pass_next  = P_POS;
                state_next = S_SCAN;
              end
            end
            KIND_NEAREST, KIND_TRAVERSE: begin
              if (count == '0) begin
                res_next = mk_err(ST_NONE);
              end else begin
                pass_next  = P_NEAR;
                state_next = S_SCAN;
              end
            end
            KIND_NEIGHBOR: begin
              if (ei_c >= cnt_c) begin
                res_next = mk_err(ST_RANGE);
              end else begin
                pass_next      = P_FETCH;
                tgt_next       = ei_w[IW-1:0];
                row_chk_next   = 1'b0;
                origin_ph_next = 1'b1;
                state_next     = S_SCAN;
              end
            end
            default: res_next = mk_err(ST_NONE);
          endcase
        end
      end

      S_SCAN: begin
        ctrl.rot = !rot_done;
        if (!rot_done) begin
          rot_cnt_next = rot_cnt + 1'b1;
        end
        if (s3_v && s3_in) begin
          case (pass)
            P_FETCH: begin
              if (s3_idx == tgt && (!row_chk || s3_e.y == ref_y)) begin
                hit_next      = 1'b1;
                best_idx_next = s3_idx;
                best_e_next   = s3_e;
              end
            end
            P_NEAR: begin
              if (!hit || s3_d2 < bestd) begin
                hit_next      = 1'b1;
                best_idx_next = s3_idx;
                best_e_next   = s3_e;
                bestd_next    = s3_d2;
              end
            end
            P_POS: begin
              if (!(ref_y < s3_e.y || (ref_y == s3_e.y && ref_x < s3_e.x))) begin
                pos_cnt_next = pos_cnt + 1'b1;
              end
            end
            P_DOWN: begin
              if (s3_idx > org_idx) begin
                if (!hit) begin
                  if (s3_e.y != ref_y) begin
                    hit_next      = 1'b1;
                    ry2_next      = s3_e.y;
                    best_idx_next = s3_idx;
                    best_e_next   = s3_e;
                    bestd_next    = DW'(s3_dx);
                  end
                end else if (s3_e.y == ry2 && DW'(s3_dx) < bestd) begin
                  best_idx_next = s3_idx;
                  best_e_next   = s3_e;
                  bestd_next    = DW'(s3_dx);
                end
              end
            end
            P_UP: begin
              // ascending walk; each new row restarts, ties go to the later entry
              if (s3_idx < org_idx && s3_e.y != ref_y) begin
                if (!hit || s3_e.y != ry2 || DW'(s3_dx) <= bestd) begin
                  hit_next      = 1'b1;
                  ry2_next      = s3_e.y;
                  best_idx_next = s3_idx;
                  best_e_next   = s3_e;
                  bestd_next    = DW'(s3_dx);
                end
              end
            end
            default: ;
          endcase
        end
        if (scan_done) begin
          state_next = S_DONE;
          case (pass)
            P_POS:  state_next = S_INSERT;
            P_NEAR: begin
              if (req.kind == KIND_TRAVERSE) begin
                state_next = S_NEARCHK;
              end else begin
                res_next = mk_ok(best_idx, best_e, 1'b0);
              end
            end
            default: begin
              if (origin_ph) begin
                state_next = S_NEARCHK;
              end else begin
                res_next = hit ? mk_ok(best_idx, best_e, moved_f) : mk_err(ST_NONE);
              end
            end
          endcase
        end
      end

      // decide on a link walk: origin is in best_idx / best_e
      S_NEARCHK: begin
        state_next = S_DONE;
        if (origin_ph || near) begin
          moved_f_next   = !origin_ph;
          origin_ph_next = 1'b0;
          org_idx_next   = best_idx;
          ref_x_next     = best_e.x;
          ref_y_next     = best_e.y;
          if (lnk_miss) begin
            res_next = mk_err(ST_NONE);
          end else begin
            pass_next    = lnk_pass;
            tgt_next     = lnk_tgt;
            row_chk_next = lnk_row;
            hit_next     = 1'b0;
            rot_cnt_next = '0;
            state_next   = S_SCAN;
          end
        end else begin
          res_next = mk_ok(best_idx, best_e, 1'b0);
        end
      end

      S_INSERT: begin
        ctrl.ins   = 1'b1;
        count_next = count + 1'b1;
        res_next   = mk_ok(pos_cnt[IW-1:0], new_e, 1'b0);
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rot_cnt   <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rot_cnt <= rot_cnt_next;
      s1_v    <= ctrl.rot;
      s2_v    <= s1_v;
      s3_v    <= s2_v;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    pass      <= pass_next;
    tgt       <= tgt_next;
    row_chk   <= row_chk_next;
    origin_ph <= origin_ph_next;
    moved_f   <= moved_f_next;
    ref_x     <= ref_x_next;
    ref_y     <= ref_y_next;
    org_idx   <= org_idx_next;
    hit       <= hit_next;
    best_idx  <= best_idx_next;
    best_e    <= best_e_next;
    bestd     <= bestd_next;
    ry2       <= ry2_next;
    pos_cnt   <= pos_cnt_next;
    res       <= res_next;
    // head pipeline: capture, distances, squares
    s1_e   <= head;
    s1_idx <= rot_cnt[IW-1:0];
    s2_e   <= s1_e;
    s2_idx <= s1_idx;
    s2_dx  <= absdiff(s1_e.x, ref_x);
    s2_dy  <= absdiff(s1_e.y, ref_y);
    s3_e   <= s2_e;
    s3_idx <= s2_idx;
    s3_dx  <= s2_dx;
    s3_d2  <= DW'(sq_x) + DW'(sq_y);
    if (load_out) begin
      out_data <= res;
    end
  end

endmodule

/* hw/rtl/spc_check.sv */
module spc_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spc_pkg::out_item_t out_data
);
  import spc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken before the first finished");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.found_index == '0 && out_data.found_tag == '0 && !out_data.moved)
    else $error("error result carries entry fields");

  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.moved |-> out_data.status == ST_OK)
    else $error("moved set on failed result");

endmodule

bind sorted_point_table_navigator spc_check u_spc_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
